// ----- sv/ctc_pkg.sv -----
`default_nettype none
package ctc_pkg;

	// geometry of the taxel store
	localparam int NUM_TRIANGLES     = 16;
	localparam int DOTS_PER_TRIANGLE = 12;
	localparam int ERROR_LIMIT       = 5;
	localparam int NSTORE            = NUM_TRIANGLES * DOTS_PER_TRIANGLE;
	localparam int ADDR_W            = $clog2(NSTORE);
	localparam int TRI_W             = 4;
	localparam int DOT_W             = 4;
	localparam int SAMPLE_W          = 16;
	localparam int CFG_DATA_W        = 8;
	localparam int CFG_IDX_W         = 2;

	// special dots and raw codes
	localparam logic [DOT_W-1:0]    TEMP_PAD_DOT      = DOT_W'(6);
	localparam logic [DOT_W-1:0]    LAST_DOT          = DOT_W'(DOTS_PER_TRIANGLE - 1);
	localparam logic [TRI_W-1:0]    ERGO_PALM_LAST_TRI = TRI_W'(4);
	localparam logic [SAMPLE_W-1:0] RAW_NOT_CONNECTED = 16'hffff;

	// reset values of the registers
	localparam logic [2:0] SKIN_RESET    = 3'd0;
	localparam logic [7:0] NOLOAD_RESET  = 8'd230;
	localparam logic [3:0] SHIFT_RESET   = 4'd2;

	typedef enum logic [2:0] {
		SKIN_TEMP_COMP      = 3'd0,
		SKIN_PALM_FINGERTIP = 3'd1,
		SKIN_TEMP_COMP_V2   = 3'd2,
		SKIN_ERGO_HAND      = 3'd3,
		SKIN_RAW_TEST       = 3'd4,
		SKIN_NO_COMP        = 3'd5
	} skin_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SKIN_TYPE    = 2'd0,
		CFG_NOLOAD_LEVEL = 2'd1,
		CFG_SAMPLE_SHIFT = 2'd2
	} cfg_index_t;

	typedef enum logic {
		REQ_LOAD    = 1'b0,
		REQ_PROCESS = 1'b1
	} req_type_t;

	// temperature drift gain tables, one entry per dot
	localparam logic [7:0] GAIN_V1 [DOTS_PER_TRIANGLE] =
		'{8'd70, 8'd96, 8'd83, 8'd38, 8'd38, 8'd70, 8'd0, 8'd45, 8'd77, 8'd164, 8'd0, 8'd77};
	localparam logic [7:0] GAIN_V2 [DOTS_PER_TRIANGLE] =
		'{8'd58, 8'd91, 8'd39, 8'd23, 8'd35, 8'd90, 8'd0, 8'd38, 8'd68, 8'd115, 8'd0, 8'd86};

	// drift gain of a dot; zero wherever the skin type has no drift
	function automatic logic [7:0] gain_of(input logic [2:0] skin,
			input logic [TRI_W-1:0] tri_idx, input logic [DOT_W-1:0] dot);
		logic [7:0] g;
		g = 8'd0;
		case (skin)
			SKIN_TEMP_COMP:    g = GAIN_V1[dot];
			SKIN_TEMP_COMP_V2: g = GAIN_V2[dot];
			SKIN_ERGO_HAND:    g = (tri_idx > ERGO_PALM_LAST_TRI) ? GAIN_V2[dot] : 8'd0;
			default:           g = 8'd0;
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

// ----- sv/ctc_if.sv -----
`default_nettype none
// command channel: loads and triangle process requests
interface ctc_cmd_if;
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic [ctc_pkg::TRI_W-1:0]       triangle;
	logic [ctc_pkg::DOT_W-1:0]       dot;
	logic [ctc_pkg::SAMPLE_W-1:0]    raw_sample;
	logic [ctc_pkg::SAMPLE_W-1:0]    cap_offset;

	modport source (output valid, req_type, triangle, dot, raw_sample, cap_offset,
		input ready);
	modport sink (input valid, req_type, triangle, dot, raw_sample, cap_offset,
		output ready);
endinterface

// result channel: one item per dot
interface ctc_res_if;
	logic                        valid;
	logic                        ready;
	logic [ctc_pkg::TRI_W-1:0]   out_triangle;
	logic [ctc_pkg::DOT_W-1:0]   out_dot;
	logic [7:0]                  pressure;
	logic                        out_of_range;
	logic                        not_connected;
	logic                        not_acked;
	logic                        force_calibration;
	logic                        last;

	modport source (output valid, out_triangle, out_dot, pressure, out_of_range,
		not_connected, not_acked, force_calibration, last, input ready);
	modport sink (input valid, out_triangle, out_dot, pressure, out_of_range,
		not_connected, not_acked, force_calibration, last, output ready);
endinterface
`default_nettype wire

// ----- sv/capacitive_taxel_compensation_top.sv -----
// Capacitive taxel compensation. Load items (req_type 0) write the raw sample and
// calibration offset of one dot into a 192-entry synchronous store and are taken
// one per cycle while no triangle is being issued; loads to a triangle or dot out
// of range are dropped. A process item (req_type 1) takes the store's single read
// port: after the accept cycle, one read of the temperature pad (dot 6) and one
// read per dot, after which the next command is taken. Results come out in dot
// order, one per cycle while not stalled, through a four-stage pipeline (store
// read, gain multiply, drift subtract, limit mapping) that stalls as a whole while
// the output register is not taken.
// The twelfth result carries last, and force_calibration when the shared counter
// of triangles with unacknowledged dots reaches its limit. Registers (skin_type,
// noload_level, sample_shift) are written through cfg_wen/cfg_idx/cfg_wdata; the
// user must write them only while the block is idle, which the block does not
// enforce. Store entries hold no defined value until loaded.
`default_nettype none
module capacitive_taxel_compensation_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wen,
	input  wire logic [ctc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [ctc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	ctc_cmd_if.sink                                 cmd,
	ctc_res_if.source                               res
);

	localparam int AW = ctc_pkg::ADDR_W;
	localparam int TW = ctc_pkg::TRI_W;
	localparam int DW = ctc_pkg::DOT_W;
	localparam int SW = ctc_pkg::SAMPLE_W;

	typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_DOTS} state_t;

	// configuration registers
	logic [2:0] skin_q;
	logic [7:0] noload_q;
	logic [3:0] shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skin_q   <= ctc_pkg::SKIN_RESET;
			noload_q <= ctc_pkg::NOLOAD_RESET;
			shift_q  <= ctc_pkg::SHIFT_RESET;
		end else if (cfg_wen) begin
			case (cfg_idx)
				ctc_pkg::CFG_SKIN_TYPE:    skin_q   <= cfg_wdata[2:0];
				ctc_pkg::CFG_NOLOAD_LEVEL: noload_q <= cfg_wdata[7:0];
				ctc_pkg::CFG_SAMPLE_SHIFT: shift_q  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	logic raw_mode;
	assign raw_mode = (skin_q == ctc_pkg::SKIN_RAW_TEST);

	// whole pipeline advances unless the output register is held
	logic out_vld_q;
	logic adv;
	assign adv = !out_vld_q || res.ready;

	// command acceptance
	state_t         state_q;
	logic [TW-1:0]  tri_q;
	logic [DW-1:0]  dot_q;
	logic           cmd_acc;
	logic           tri_ok;
	logic           dot_ok;
	logic           load_wr;
	logic [AW-1:0]  load_addr;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign tri_ok    = int'(cmd.triangle) < ctc_pkg::NUM_TRIANGLES;
	assign dot_ok    = int'(cmd.dot) < ctc_pkg::DOTS_PER_TRIANGLE;
	assign load_wr   = cmd_acc && (cmd.req_type == ctc_pkg::REQ_LOAD) && tri_ok && dot_ok;
	assign load_addr = AW'(cmd.triangle) * AW'(ctc_pkg::DOTS_PER_TRIANGLE) + AW'(cmd.dot);

	// read issue sequencer: pad first, then dots in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tri_q   <= '0;
			dot_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc && cmd.req_type == ctc_pkg::REQ_PROCESS && tri_ok) begin
						state_q <= ST_PAD;
						tri_q   <= cmd.triangle;
					end
				end
				ST_PAD: begin
					if (adv) begin
						state_q <= ST_DOTS;
						dot_q   <= '0;
					end
				end
				ST_DOTS: begin
					if (adv) begin
						if (dot_q == ctc_pkg::LAST_DOT) begin
							state_q <= ST_IDLE;
						end else begin
							dot_q <= dot_q + DW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic          issue_vld;
	logic          issue_pad;
	logic [AW-1:0] issue_addr;
	assign issue_vld  = (state_q != ST_IDLE);
	assign issue_pad  = (state_q == ST_PAD);
	assign issue_addr = AW'(tri_q) * AW'(ctc_pkg::DOTS_PER_TRIANGLE)
		+ AW'(issue_pad ? ctc_pkg::TEMP_PAD_DOT : dot_q);

	// sample store: {raw, offset} per dot
	logic [2*SW-1:0] store_mem [ctc_pkg::NSTORE];
	logic [2*SW-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (load_wr) begin
			store_mem[load_addr] <= {cmd.raw_sample, cmd.cap_offset};
		end
		if (adv && issue_vld) begin
			rd_s1 <= store_mem[issue_addr];
		end
	end

	// stage 1 tags
	logic          v_s1;
	logic          pad_s1;
	logic [TW-1:0] tri_s1;
	logic [DW-1:0] dot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pad_s1 <= issue_pad;
			tri_s1 <= tri_q;
			dot_s1 <= dot_q;
		end
	end

	// stage 1: pad difference magnitude, then gain multiply for dots
	logic [SW-1:0] raw1;
	logic [SW-1:0] off1;
	logic          pad_pos;
	logic [SW-1:0] pad_abs;
	logic [SW-3:0] pad_mag_q;
	logic          pad_neg_q;
	logic [7:0]    gain1;

	assign raw1    = rd_s1[2*SW-1:SW];
	assign off1    = rd_s1[SW-1:0];
	assign pad_pos = raw1 > off1;
	assign pad_abs = pad_pos ? (raw1 - off1) : (off1 - raw1);
	assign gain1   = ctc_pkg::gain_of(skin_q, tri_s1, dot_s1);

	logic             v_s2;
	logic [SW+5:0]    prod_s2;
	logic             neg_s2;
	logic [SW-1:0]    raw_s2;
	logic [SW-1:0]    off_s2;
	logic [TW-1:0]    tri_s2;
	logic [DW-1:0]    dot_s2;

	always_ff @(posedge clk) begin
		if (adv && v_s1 && pad_s1) begin
			pad_neg_q <= !pad_pos;
			pad_mag_q <= pad_abs[SW-1:2];
		end
		if (adv) begin
			prod_s2 <= (SW+6)'(pad_mag_q) * (SW+6)'(gain1);
			neg_s2  <= pad_neg_q;
			raw_s2  <= raw1;
			off_s2  <= off1;
			tri_s2  <= tri_s1;
			dot_s2  <= dot_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && !pad_s1;
		end
	end

	// stage 2: drift (floor of a negative product) and compensated value
	logic [SW+6:0]        prod_rnd;
	logic [SW+1:0]        drift_mag;
	logic signed [19:0]   diff2;
	logic signed [19:0]   v2;
	logic                 nc2;
	logic                 na2;

	assign prod_rnd  = neg_s2 ? ((SW+7)'(prod_s2) + (SW+7)'(31)) : (SW+7)'(prod_s2);
	assign drift_mag = prod_rnd[SW+6:5];
	assign diff2     = signed'(20'(raw_s2)) - signed'(20'(off_s2));
	assign v2        = neg_s2 ? (diff2 + signed'(20'(drift_mag)))
		: (diff2 - signed'(20'(drift_mag)));
	assign nc2       = (raw_s2 == ctc_pkg::RAW_NOT_CONNECTED);
	assign na2       = !nc2 && (raw_s2 == '0) && (off_s2 != '0);

	logic               v_s3;
	logic signed [19:0] v_s3v;
	logic [7:0]         rawlo_s3;
	logic               nc_s3;
	logic               na_s3;
	logic [TW-1:0]      tri_s3;
	logic [DW-1:0]      dot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s3v    <= v2;
			rawlo_s3 <= raw_s2[7:0];
			nc_s3    <= nc2;
			na_s3    <= na2;
			tri_s3   <= tri_s2;
			dot_s3   <= dot_s2;
		end
	end

	// stage 3: map around noload with saturation and range flags
	logic [22:0]        up_u;
	logic [22:0]        bot_u;
	logic signed [25:0] up_s;
	logic signed [25:0] bot_s;
	logic signed [25:0] v_ext;
	logic signed [19:0] v_sh;
	logic [7:0]         press3;
	logic               oor3;
	logic               nc3;
	logic               na3;

	assign up_u  = 23'(8'(8'd255 - noload_q)) << shift_q;
	assign bot_u = 23'(noload_q) << shift_q;
	assign up_s  = signed'(26'(up_u));
	assign bot_s = signed'(26'(bot_u));
	assign v_ext = 26'(v_s3v);
	assign v_sh  = v_s3v >>> shift_q;

	always_comb begin
		press3 = 8'd0;
		oor3   = 1'b0;
		nc3    = 1'b0;
		na3    = 1'b0;
		if (raw_mode) begin
			press3 = rawlo_s3;
		end else begin
			if (v_ext <= -up_s) begin
				press3 = 8'd255;
			end else if (v_ext >= bot_s) begin
				press3 = 8'd0;
			end else begin
				press3 = noload_q - v_sh[7:0];
			end
			oor3 = (v_ext <= -(up_s <<< 1)) || (v_ext >= (bot_s <<< 1));
			nc3  = nc_s3;
			na3  = na_s3;
		end
	end

	// unacknowledged-triangle counter, settled on the last dot
	logic [2:0] err_cnt_q;
	logic       nack_acc_q;
	logic       nack_all;
	logic [2:0] err_inc;
	logic       last3;
	logic       force3;

	assign last3    = (dot_s3 == ctc_pkg::LAST_DOT);
	assign nack_all = na3 || ((dot_s3 != '0) && nack_acc_q);
	assign err_inc  = err_cnt_q + 3'd1;
	assign force3   = last3 && nack_all && (err_inc >= 3'(ctc_pkg::ERROR_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_cnt_q  <= '0;
			nack_acc_q <= 1'b0;
		end else if (adv && v_s3) begin
			nack_acc_q <= nack_all;
			if (last3 && nack_all) begin
				err_cnt_q <= force3 ? 3'd0 : err_inc;
			end
		end
	end

	// output register
	logic [TW-1:0] out_tri_q;
	logic [DW-1:0] out_dot_q;
	logic [7:0]    out_press_q;
	logic          out_oor_q;
	logic          out_nc_q;
	logic          out_na_q;
	logic          out_force_q;
	logic          out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			out_tri_q   <= tri_s3;
			out_dot_q   <= dot_s3;
			out_press_q <= press3;
			out_oor_q   <= oor3;
			out_nc_q    <= nc3;
			out_na_q    <= na3;
			out_force_q <= force3;
			out_last_q  <= last3;
		end
	end

	assign res.valid             = out_vld_q;
	assign res.out_triangle      = out_tri_q;
	assign res.out_dot           = out_dot_q;
	assign res.pressure          = out_press_q;
	assign res.out_of_range      = out_oor_q;
	assign res.not_connected     = out_nc_q;
	assign res.not_acked         = out_na_q;
	assign res.force_calibration = out_force_q;
	assign res.last              = out_last_q;

endmodule
`default_nettype wire

// ----- sv/ctc_checker.sv -----
`default_nettype none
module ctc_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         res_valid,
	input wire logic                         res_ready,
	input wire logic [ctc_pkg::DOT_W-1:0]    res_dot,
	input wire logic [7:0]                   res_pressure,
	input wire logic                         res_nc,
	input wire logic                         res_na,
	input wire logic                         res_force,
	input wire logic                         res_last
);

	// a held item keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_pressure) && $stable(res_dot))
		else $error("result item changed while stalled");

	// last marks the final dot of a triangle and nothing else
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_last == (res_dot == ctc_pkg::LAST_DOT)))
		else $error("last does not match the final dot");

	// recalibration request only on a triangle's last item
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_force |-> res_last)
		else $error("force_calibration away from last");

	// a dot is never both unconnected and unacknowledged
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_nc && res_na))
		else $error("not_connected and not_acked together");

	// dots of a triangle follow one another in order
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last ##1 res_valid |->
		res_dot == $past(res_dot) + ctc_pkg::DOT_W'(1))
		else $error("dot order broken");

endmodule

bind capacitive_taxel_compensation_top ctc_checker u_ctc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_dot      (res.out_dot),
	.res_pressure (res.pressure),
	.res_nc       (res.not_connected),
	.res_na       (res.not_acked),
	.res_force    (res.force_calibration),
	.res_last     (res.last)
);
`default_nettype wire
